// File: rtl/afbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the box decoder.
// Used by every module of the block; depends on nothing else.
package afbd_pkg;

    // Default block parameters.
    localparam int MAX_GRID        = 128;
    localparam int SIGMOID_ENTRIES = 1024;
    localparam int QUEUE_DEPTH     = 8;

    // Field widths fixed by the item formats.
    localparam int LOGIT_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int COORD_W  = 16;
    localparam int POS_W    = 7;
    localparam int SHIFT_W  = 3;
    localparam int PIX_W    = 11;
    localparam int CONF_W   = 10;
    localparam int BOX_W    = 15;
    localparam int CX_W     = 21;
    localparam int SIZE_W   = 14;
    localparam int CORNER_W = 24;

    // Input item layout inside the stream data word.
    localparam int NUM_LOGITS = 5;
    localparam int COL_LSB    = 80;
    localparam int ROW_LSB    = 87;
    localparam int SHIFT_LSB  = 94;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 112;

    // Logit slots in the input word.
    localparam int LOGIT_OBJ = 0;
    localparam int LOGIT_X   = 1;
    localparam int LOGIT_Y   = 2;
    localparam int LOGIT_W_SLOT = 3;
    localparam int LOGIT_H   = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BOX         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOX         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd4;

    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd22938;
    localparam logic [BOX_W-1:0]   RST_MIN_BOX         = 15'd160;
    localparam logic [BOX_W-1:0]   RST_MAX_BOX         = 15'd10240;
    localparam logic [PIX_W-1:0]   RST_IMAGE_WIDTH     = 11'd640;
    localparam logic [PIX_W-1:0]   RST_IMAGE_HEIGHT    = 11'd640;

    // Sigmoid table construction.
    localparam int EXP_BITS = 12;
    localparam longint unsigned EXP_STEP_Q32 = 64'd4278222805;

    typedef struct packed {
        logic [SCORE_W-1:0] score_threshold;
        logic [BOX_W-1:0]   min_box;
        logic [BOX_W-1:0]   max_box;
        logic [PIX_W-1:0]   image_width;
        logic [PIX_W-1:0]   image_height;
    } afbd_cfg_t;

    // One classified cell as it travels from the front to the back.
    typedef struct packed {
        logic                      keep;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic signed [COORD_W-1:0] box_right;
        logic signed [COORD_W-1:0] box_bottom;
        logic [SCORE_W-1:0]        score;
        logic                      last;
        logic [PIX_W-1:0]          center_x;
        logic [PIX_W-1:0]          center_y;
    } afbd_cell_t;

    // Shift-subtract division, used only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q32 product with round half up.
    function automatic longint unsigned qmul32(input longint unsigned a,
                                               input longint unsigned b);
        return (a * b + 64'h0000_0000_8000_0000) >> 32;
    endfunction

    // Sigmoid table entry idx of a table with the given number of entries.
    function automatic logic [SCORE_W-1:0] sig_entry(input int idx, input int entries);
        longint unsigned pw [EXP_BITS];
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        int              x;
        int              a;
        pw[0] = EXP_STEP_Q32;
        for (int k = 1; k < EXP_BITS; k++)
        begin
            pw[k] = qmul32(pw[k-1], pw[k-1]);
        end
        x = -2048 + int'(udiv64(64'(idx) * 64'd4096, 64'(entries)));
        a = (x < 0) ? -x : x;
        e = 64'd1 << 32;
        for (int k = 0; k < EXP_BITS; k++)
        begin
            if (a[k])
            begin
                e = qmul32(e, pw[k]);
            end
        end
        den = (64'd1 << 32) + e;
        if (x >= 0)
        begin
            s = udiv64((64'd1 << 48) + (den >> 1), den);
        end
        else
        begin
            s = udiv64(e * 64'd65536 + (den >> 1), den);
        end
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// File: rtl/afbd_front.sv
`timescale 1ns / 1ps
// Front part of the box decoder: sigmoid lookups, centre and size decode,
// corner and keep classification. Depends on afbd_pkg.
module afbd_front #(
    parameter int MAX_GRID        = afbd_pkg::MAX_GRID,
    parameter int SIGMOID_ENTRIES = afbd_pkg::SIGMOID_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [afbd_pkg::IN_DATA_W-1:0] in_data,
    input  logic                           in_last,
    input  afbd_pkg::afbd_cfg_t            cfg,
    output logic                           out_valid,
    output afbd_pkg::afbd_cell_t           out_cell
);

    localparam int IDX_W      = $clog2(SIGMOID_ENTRIES);
    localparam int IDX_PROD_W = 12 + $clog2(SIGMOID_ENTRIES + 1);
    localparam int NL         = afbd_pkg::NUM_LOGITS;

    typedef logic [afbd_pkg::SCORE_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

    function automatic sig_rom_t build_rom();
        sig_rom_t rom;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            rom[i] = afbd_pkg::sig_entry(i, SIGMOID_ENTRIES);
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_rom();

    // Clamp to [-8, 8) and scale the biased logit onto the table.
    function automatic logic [IDX_W-1:0] logit_index(input logic signed [15:0] logit);
        logic [11:0]           biased;
        logic [IDX_PROD_W-1:0] prod;
        if (logit < -16'sd2048)
        begin
            biased = 12'd0;
        end
        else if (logit > 16'sd2047)
        begin
            biased = 12'hFFF;
        end
        else
        begin
            biased = logit[11:0] ^ 12'h800;
        end
        prod = IDX_PROD_W'(biased) * IDX_PROD_W'(SIGMOID_ENTRIES);
        return prod[12 +: IDX_W];
    endfunction

    // (2s - 0.5 + pos) << shift in Q11.4, rounded half up.
    function automatic logic signed [afbd_pkg::CX_W-1:0] centre_q4(
        input logic [15:0] s, input logic [6:0] pos, input logic [2:0] shift);
        logic signed [24:0] t;
        logic signed [31:0] v;
        logic signed [32:0] r;
        t = $signed({2'b00, pos, 16'd0}) + $signed({8'd0, s, 1'b0}) - 25'sd32768;
        v = 32'(t);
        v = v <<< shift;
        r = 33'(v) + 33'sd2048;
        return r[32:12];
    endfunction

    // 4 s^2 << shift in Q11.4, rounded half up.
    function automatic logic [afbd_pkg::SIZE_W-1:0] size_q4(input logic [31:0] sq,
                                                           input logic [2:0] shift);
        logic [39:0] sh;
        sh = (40'(sq) << shift) + 40'd33554432;
        return sh[39:26];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v < -24'sd32768)
        begin
            return -16'sd32768;
        end
        else if (v > 24'sd32767)
        begin
            return 16'sd32767;
        end
        return v[15:0];
    endfunction

    // Stage A: table indexes.
    logic                     va_reg;
    logic [IDX_W-1:0]         idx_a_reg [NL];
    logic [2:0]               shift_a_reg;
    logic [6:0]               col_a_reg;
    logic [6:0]               row_a_reg;
    logic                     grid_a_reg;
    logic                     last_a_reg;

    // Stage B: sigmoid values.
    logic                     vb_reg;
    logic [15:0]              sig_b_reg [NL];
    logic [2:0]               shift_b_reg;
    logic [6:0]               col_b_reg;
    logic [6:0]               row_b_reg;
    logic                     grid_b_reg;
    logic                     last_b_reg;

    // Stage C: squares and centres.
    logic                     vc_reg;
    logic [31:0]              sqw_c_reg;
    logic [31:0]              sqh_c_reg;
    logic signed [afbd_pkg::CX_W-1:0] cx_c_reg;
    logic signed [afbd_pkg::CX_W-1:0] cy_c_reg;
    logic [15:0]              score_c_reg;
    logic [2:0]               shift_c_reg;
    logic                     grid_c_reg;
    logic                     last_c_reg;

    // Stage D: sizes.
    logic                     vd_reg;
    logic [afbd_pkg::SIZE_W-1:0] w_d_reg;
    logic [afbd_pkg::SIZE_W-1:0] h_d_reg;
    logic signed [afbd_pkg::CX_W-1:0] cx_d_reg;
    logic signed [afbd_pkg::CX_W-1:0] cy_d_reg;
    logic [15:0]              score_d_reg;
    logic                     grid_d_reg;
    logic                     last_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NL; k++)
        begin
            idx_a_reg[k] <= logit_index($signed(in_data[16*k +: 16]));
            sig_b_reg[k] <= SIG_ROM[idx_a_reg[k]];
        end
        col_a_reg   <= in_data[afbd_pkg::COL_LSB +: afbd_pkg::POS_W];
        row_a_reg   <= in_data[afbd_pkg::ROW_LSB +: afbd_pkg::POS_W];
        shift_a_reg <= in_data[afbd_pkg::SHIFT_LSB +: afbd_pkg::SHIFT_W];
        grid_a_reg  <= (int'(in_data[afbd_pkg::COL_LSB +: afbd_pkg::POS_W]) < MAX_GRID)
                    && (int'(in_data[afbd_pkg::ROW_LSB +: afbd_pkg::POS_W]) < MAX_GRID);
        last_a_reg  <= in_last;

        col_b_reg   <= col_a_reg;
        row_b_reg   <= row_a_reg;
        shift_b_reg <= shift_a_reg;
        grid_b_reg  <= grid_a_reg;
        last_b_reg  <= last_a_reg;

        sqw_c_reg   <= 32'(sig_b_reg[afbd_pkg::LOGIT_W_SLOT])
                     * 32'(sig_b_reg[afbd_pkg::LOGIT_W_SLOT]);
        sqh_c_reg   <= 32'(sig_b_reg[afbd_pkg::LOGIT_H]) * 32'(sig_b_reg[afbd_pkg::LOGIT_H]);
        cx_c_reg    <= centre_q4(sig_b_reg[afbd_pkg::LOGIT_X], col_b_reg, shift_b_reg);
        cy_c_reg    <= centre_q4(sig_b_reg[afbd_pkg::LOGIT_Y], row_b_reg, shift_b_reg);
        score_c_reg <= sig_b_reg[afbd_pkg::LOGIT_OBJ];
        shift_c_reg <= shift_b_reg;
        grid_c_reg  <= grid_b_reg;
        last_c_reg  <= last_b_reg;

        w_d_reg     <= size_q4(sqw_c_reg, shift_c_reg);
        h_d_reg     <= size_q4(sqh_c_reg, shift_c_reg);
        cx_d_reg    <= cx_c_reg;
        cy_d_reg    <= cy_c_reg;
        score_d_reg <= score_c_reg;
        grid_d_reg  <= grid_c_reg;
        last_d_reg  <= last_c_reg;
    end

    // Corners, bounds and keep decision on the stage D registers.
    logic signed [22:0] left;
    logic signed [22:0] top;
    logic signed [afbd_pkg::CORNER_W-1:0] right;
    logic signed [afbd_pkg::CORNER_W-1:0] bottom;
    logic signed [afbd_pkg::CX_W-1:0] cx_round;
    logic signed [afbd_pkg::CX_W-1:0] cy_round;
    logic size_ok;
    logic bounds_ok;

    always_comb
    begin
        left   = $signed({{2{cx_d_reg[afbd_pkg::CX_W-1]}}, cx_d_reg})
               - $signed({10'd0, w_d_reg[afbd_pkg::SIZE_W-1:1]});
        top    = $signed({{2{cy_d_reg[afbd_pkg::CX_W-1]}}, cy_d_reg})
               - $signed({10'd0, h_d_reg[afbd_pkg::SIZE_W-1:1]});
        right  = afbd_pkg::CORNER_W'(left) + $signed({10'd0, w_d_reg});
        bottom = afbd_pkg::CORNER_W'(top) + $signed({10'd0, h_d_reg});

        size_ok   = ({1'b0, w_d_reg} >= cfg.min_box) && ({1'b0, h_d_reg} >= cfg.min_box)
                 && ({1'b0, w_d_reg} <= cfg.max_box) && ({1'b0, h_d_reg} <= cfg.max_box);
        bounds_ok = !left[22] && !top[22]
                 && (right <= $signed({9'd0, cfg.image_width, 4'd0}))
                 && (bottom <= $signed({9'd0, cfg.image_height, 4'd0}));

        cx_round = cx_d_reg + 21'sd8;
        cy_round = cy_d_reg + 21'sd8;

        out_valid           = vd_reg;
        out_cell.keep       = (score_d_reg >= cfg.score_threshold) && size_ok && bounds_ok
                           && grid_d_reg;
        out_cell.box_left   = sat16(afbd_pkg::CORNER_W'(left));
        out_cell.box_top    = sat16(afbd_pkg::CORNER_W'(top));
        out_cell.box_right  = sat16(right);
        out_cell.box_bottom = sat16(bottom);
        out_cell.score      = score_d_reg;
        out_cell.last       = last_d_reg;
        out_cell.center_x   = cx_round[14:4];
        out_cell.center_y   = cy_round[14:4];
    end

endmodule

// File: rtl/afbd_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified cells between the front and the back part.
// Depends on afbd_pkg for the cell type.
module afbd_fifo #(
    parameter int DEPTH = afbd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  afbd_pkg::afbd_cell_t push_cell,
    input  logic                 pop,
    output afbd_pkg::afbd_cell_t pop_cell,
    output logic                 not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    afbd_pkg::afbd_cell_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cell;
        end
    end

    assign pop_cell  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

    // The credit count upstream must keep the queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH)) || pop)
        else $error("cell queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("cell queue read while empty");

endmodule

// File: rtl/afbd_back.sv
`timescale 1ns / 1ps
// Back part of the box decoder: best-box tracker and the output register.
// Depends on afbd_pkg.
module afbd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  afbd_pkg::afbd_cell_t            q_cell,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [afbd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    logic                          best_valid_reg;
    logic                          best_valid_next;
    logic [afbd_pkg::SCORE_W-1:0]  best_score_reg;
    logic [afbd_pkg::SCORE_W-1:0]  best_score_next;
    logic [afbd_pkg::PIX_W-1:0]    best_x_reg;
    logic [afbd_pkg::PIX_W-1:0]    best_x_next;
    logic [afbd_pkg::PIX_W-1:0]    best_y_reg;
    logic [afbd_pkg::PIX_W-1:0]    best_y_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [afbd_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [afbd_pkg::OUT_DATA_W-1:0] out_data_next;
    logic                          out_keep_reg;
    logic                          out_last_reg;

    logic                          take;
    logic                          upd;
    logic                          eff_valid;
    logic [afbd_pkg::SCORE_W-1:0]  eff_score;
    logic [afbd_pkg::PIX_W-1:0]    eff_x;
    logic [afbd_pkg::PIX_W-1:0]    eff_y;
    logic [25:0]                   conf_prod;
    logic [afbd_pkg::PIX_W-1:0]    rep_x;
    logic [afbd_pkg::PIX_W-1:0]    rep_y;
    logic [afbd_pkg::CONF_W-1:0]   rep_conf;

    assign take  = q_valid && (!out_valid_reg || m_tready);
    assign q_pop = take;

    always_comb
    begin
        // A later box wins only on a strictly higher score.
        upd       = q_cell.keep && (!best_valid_reg || (q_cell.score > best_score_reg));
        eff_valid = upd || best_valid_reg;
        eff_score = upd ? q_cell.score : best_score_reg;
        eff_x     = upd ? q_cell.center_x : best_x_reg;
        eff_y     = upd ? q_cell.center_y : best_y_reg;
        conf_prod = 26'(eff_score) * 26'd1000 + 26'd32768;

        if (q_cell.last && eff_valid)
        begin
            rep_x    = eff_x;
            rep_y    = eff_y;
            rep_conf = conf_prod[25:16];
        end
        else
        begin
            rep_x    = '0;
            rep_y    = '0;
            rep_conf = '0;
        end

        best_valid_next = best_valid_reg;
        best_score_next = best_score_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        if (take)
        begin
            if (q_cell.last)
            begin
                best_valid_next = 1'b0;
                best_score_next = '0;
                best_x_next     = '0;
                best_y_next     = '0;
            end
            else
            begin
                best_valid_next = eff_valid;
                best_score_next = eff_score;
                best_x_next     = eff_x;
                best_y_next     = eff_y;
            end
        end

        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        out_data_next = {rep_conf, rep_y, rep_x, q_cell.score, q_cell.box_bottom,
                         q_cell.box_right, q_cell.box_top, q_cell.box_left};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_score_reg <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_valid_reg <= best_valid_next;
            best_score_reg <= best_score_next;
            best_x_reg     <= best_x_next;
            best_y_reg     <= best_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
            out_keep_reg <= q_cell.keep;
            out_last_reg <= q_cell.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_keep_reg;
    assign m_tlast  = out_last_reg;

    // The tracker starts every frame empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && q_cell.last |=> !best_valid_reg && (best_score_reg == '0))
        else $error("tracker not cleared after the last cell of a frame");

endmodule

// File: rtl/anchor_free_box_decode_select_top.sv
`timescale 1ns / 1ps
// Top level of the anchor-free box decoder with best-box selection.
// Depends on afbd_pkg, afbd_front, afbd_fifo and afbd_back.
//
// Path: an accepted input item passes four front stages (index, sigmoid
// table, squares and centres, sizes), then the cell queue and the output
// register before it is valid on m_tvalid. Throughput: one item per cycle
// while s_tready is high. The front never stalls; input is accepted
// while fewer than QUEUE_DEPTH items sit between the input and the output
// register, so a stalled output fills the queue and then holds s_tready low.
// Reset (rst_n, asynchronous, active low) empties the pipeline and the queue,
// clears the best-box tracker and loads the register defaults.
module anchor_free_box_decode_select_top #(
    parameter int MAX_GRID        = afbd_pkg::MAX_GRID,
    parameter int SIGMOID_ENTRIES = afbd_pkg::SIGMOID_ENTRIES,
    parameter int QUEUE_DEPTH     = afbd_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Input items. s_tdata from bit 0 up: obj_logit, x_logit, y_logit,
    // w_logit, h_logit (16 bits each), col (7), row (7), stride_shift (3),
    // then zero padding to 104 bits. s_tlast carries last_in_frame.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [afbd_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,

    // Result items. m_tdata from bit 0 up: box_left, box_top, box_right,
    // box_bottom, score (16 bits each), best_center_x (11), best_center_y (11),
    // best_conf_milli (10). m_tuser carries keep; m_tlast carries frame_done.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [afbd_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast,

    // Register writes: 0 score_threshold, 1 min_box, 2 max_box,
    // 3 image_width, 4 image_height. Other indexes are ignored.
    input  logic                             cfg_wr_en,
    input  logic [afbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afbd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

    afbd_pkg::afbd_cfg_t  cfg_reg;
    afbd_pkg::afbd_cfg_t  cfg_next;

    logic                 accept;
    logic                 front_valid;
    afbd_pkg::afbd_cell_t front_cell;
    logic                 q_valid;
    afbd_pkg::afbd_cell_t q_cell;
    logic                 q_pop;

    // Items accepted but not yet moved into the output register.
    logic [CREDIT_W-1:0]  credit_reg;
    logic [CREDIT_W-1:0]  credit_next;

    assign s_tready = (credit_reg < CREDIT_W'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !q_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (q_pop && !accept)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    // Register file. Writes must be made only while the block is idle; the block itself does not enforce this.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                afbd_pkg::CFG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_wdata;
                afbd_pkg::CFG_MIN_BOX:
                    cfg_next.min_box = cfg_wdata[afbd_pkg::BOX_W-1:0];
                afbd_pkg::CFG_MAX_BOX:
                    cfg_next.max_box = cfg_wdata[afbd_pkg::BOX_W-1:0];
                afbd_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_wdata[afbd_pkg::PIX_W-1:0];
                afbd_pkg::CFG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_wdata[afbd_pkg::PIX_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold <= afbd_pkg::RST_SCORE_THRESHOLD;
            cfg_reg.min_box         <= afbd_pkg::RST_MIN_BOX;
            cfg_reg.max_box         <= afbd_pkg::RST_MAX_BOX;
            cfg_reg.image_width     <= afbd_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height    <= afbd_pkg::RST_IMAGE_HEIGHT;
            credit_reg              <= '0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            credit_reg <= credit_next;
        end
    end

    afbd_front #(
        .MAX_GRID        (MAX_GRID),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_cell  (front_cell)
    );

    afbd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_cell (front_cell),
        .pop       (q_pop),
        .pop_cell  (q_cell),
        .not_empty (q_valid)
    );

    afbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cell   (q_cell),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The credit count bounds the items between input and output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_W'(QUEUE_DEPTH))
        else $error("more items in flight than the cell queue holds");

endmodule
